>>> rtl/core/fit_policy_block_allocator_assert.svh
// Assertion macros shared by the checker of the partition allocator.
// Each macro expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FPBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpba assertion failed");

// Next-cycle implication.
`define FPBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpba assertion failed");

`endif

>>> rtl/core/fpba_pkg.sv
// Package of the partition allocator: request, policy and register codes,
// and the control group broadcast to the cell chain. No dependencies.
package fpba_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RESTORE = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_mode_t;

  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam int CFG_DATA_BITS   = 7;
  localparam logic [CFG_DATA_BITS-1:0] BLOCK_COUNT_RESET = 7'd64;

  localparam int TYPE_BITS  = 2;
  localparam int INDEX_BITS = 6;
  localparam int FIELD_SIZE_BITS = 16;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic restore;
    logic load;
    logic wr_rem;
  } cell_ctrl_t;

endpackage

>>> rtl/core/fpba_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing; field widths are fixed by the block's item format.
interface fpba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  block_index;
  logic [15:0] size_value;

  modport source (output valid, output req_type, output block_index, output size_value,
                  input ready);
  modport sink (input valid, input req_type, input block_index, input size_value,
                output ready);
endinterface

interface fpba_res_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [5:0]  chosen_block;
  logic [15:0] remaining_after;

  modport source (output valid, output granted, output chosen_block,
                  output remaining_after, input ready);
  modport sink (input valid, input granted, input chosen_block, input remaining_after,
                output ready);
endinterface

>>> rtl/core/fpba_cell.sv
// One cell of the partition chain: holds an original and a remaining size.
// The remaining size rotates to the neighbor on shift. Uses fpba_pkg.
module fpba_cell #(
  parameter int SIZE_BITS = 16
) (
  input  logic                   clk,
  input  fpba_pkg::cell_ctrl_t   ctrl,
  input  logic                   sel,
  input  logic [SIZE_BITS-1:0]   wdata,
  input  logic [SIZE_BITS-1:0]   rem_in,
  output logic [SIZE_BITS-1:0]   rem
);

  logic [SIZE_BITS-1:0] orig;

  // Loads and write-backs only happen while the ring sits at its home position.
  always_ff @(posedge clk) begin
    if (sel && ctrl.load) begin
      orig <= wdata;
      rem  <= wdata;
    end else if (sel && ctrl.wr_rem) begin
      rem <= wdata;
    end else if (ctrl.restore) begin
      rem <= orig;
    end else if (ctrl.shift) begin
      rem <= rem_in;
    end
  end

endmodule

>>> rtl/core/fit_policy_block_allocator.sv
// Top level of the partition allocator: cell chain plus scan controller.
// Depends on fpba_pkg, fpba_if and fpba_cell.

// Load and restore requests give their result in the next cycle. An allocate request
// is accepted in the idle state; in the scan state the remaining sizes rotate once
// around the chain of cells past the compare logic at its head, and the write state
// writes the chosen block back and registers the result.
// A new request is taken whenever the controller is idle and the result register is
// empty or being drained. No clearing pass follows reset; table entries are defined
// once they are loaded.
module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [fpba_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  fpba_req_if.sink                            req,
  fpba_res_if.source                          res
);

  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int KW  = IW + 1;
  localparam int IXW = (KW > fpba_pkg::INDEX_BITS) ? KW : fpba_pkg::INDEX_BITS;
  localparam int NW  = (KW > fpba_pkg::CFG_DATA_BITS) ? KW : fpba_pkg::CFG_DATA_BITS;
  localparam int XB  = (SIZE_BITS > fpba_pkg::FIELD_SIZE_BITS) ? SIZE_BITS
                                                               : fpba_pkg::FIELD_SIZE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t                      state;
  fpba_pkg::fit_mode_t         fit_mode;
  logic [fpba_pkg::CFG_DATA_BITS-1:0] block_count;
  logic [IW-1:0]               next_ptr;

  // Scan registers.
  fpba_pkg::fit_mode_t         scan_mode;
  logic [SIZE_BITS-1:0]        need;
  logic [KW-1:0]               n_eff;
  logic [IW-1:0]               scan_start;
  logic [KW-1:0]               k;
  logic                        found;
  logic [IW-1:0]               pick;
  logic [SIZE_BITS-1:0]        pick_rem;
  logic                        found_hi;
  logic [IW-1:0]               pick_hi;
  logic [SIZE_BITS-1:0]        rem_hi;

  // Result register.
  logic                        out_valid;
  logic                        out_granted;
  logic [5:0]                  out_block;
  logic [15:0]                 out_rem;

  logic                        accept;
  logic [XB-1:0]               size_x;
  logic [SIZE_BITS-1:0]        size_m;
  logic [IXW-1:0]              idx_x;
  logic                        load_ok;
  logic [NW-1:0]               bc_x;
  logic [KW-1:0]               n_calc;
  logic [IW-1:0]               use_pick;
  logic [SIZE_BITS-1:0]        use_rem;
  logic [SIZE_BITS-1:0]        left;
  logic [XB-1:0]               left_x;
  logic [IXW-1:0]              pick_x;
  logic [SIZE_BITS-1:0]        head_rem;
  logic                        fits;
  logic                        in_range;

  fpba_pkg::cell_ctrl_t        ctrl;
  logic [IW-1:0]               wr_idx;
  logic [SIZE_BITS-1:0]        wdata;
  logic [SIZE_BITS-1:0]        rem_q [MAX_BLOCKS];

  assign req.ready = (state == ST_IDLE) && (!out_valid || res.ready);
  assign accept    = req.valid && req.ready;

  assign size_x  = XB'(req.size_value);
  assign size_m  = size_x[SIZE_BITS-1:0];
  assign idx_x   = IXW'(req.block_index);
  assign load_ok = idx_x < IXW'(MAX_BLOCKS);
  assign bc_x    = NW'(block_count);
  assign n_calc  = (bc_x > NW'(MAX_BLOCKS)) ? KW'(MAX_BLOCKS) : bc_x[KW-1:0];

  assign use_pick = found_hi ? pick_hi : pick;
  assign use_rem  = found_hi ? rem_hi : pick_rem;
  assign left     = use_rem - need;
  assign left_x   = XB'(left);
  assign pick_x   = IXW'(use_pick);

  assign head_rem = rem_q[0];
  assign fits     = head_rem >= need;
  assign in_range = k < n_eff;

  always_comb begin
    ctrl.shift   = (state == ST_SCAN);
    ctrl.restore = accept && (req.req_type == fpba_pkg::REQ_RESTORE);
    ctrl.load    = accept && (req.req_type == fpba_pkg::REQ_LOAD) && load_ok;
    ctrl.wr_rem  = (state == ST_WRITE) && found;
    wr_idx       = (state == ST_WRITE) ? use_pick : idx_x[IW-1:0];
    wdata        = (state == ST_WRITE) ? left : size_m;
  end

  // Cell i takes the remaining size of cell i+1, so the head shows entry k after k shifts.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_BLOCKS;
    fpba_cell #(.SIZE_BITS(SIZE_BITS)) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .sel    (wr_idx == IW'(i)),
      .wdata  (wdata),
      .rem_in (rem_q[NB]),
      .rem    (rem_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      next_ptr    <= '0;
      fit_mode    <= fpba_pkg::FIT_FIRST;
      block_count <= fpba_pkg::BLOCK_COUNT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fpba_pkg::CFG_FIT_MODE:    fit_mode    <= fpba_pkg::fit_mode_t'(cfg_data[1:0]);
          fpba_pkg::CFG_BLOCK_COUNT: block_count <= cfg_data;
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.req_type)
              fpba_pkg::REQ_ALLOC: begin
                scan_mode  <= fit_mode;
                need       <= size_m;
                n_eff      <= n_calc;
                scan_start <= (KW'(next_ptr) < n_calc) ? next_ptr : '0;
                found      <= 1'b0;
                found_hi   <= 1'b0;
                k          <= '0;
                state      <= ST_SCAN;
              end
              fpba_pkg::REQ_RESTORE: begin
                next_ptr    <= '0;
                out_valid   <= 1'b1;
                out_granted <= 1'b0;
                out_block   <= '0;
                out_rem     <= '0;
              end
              default: begin
                out_valid   <= 1'b1;
                out_granted <= 1'b0;
                out_block   <= '0;
                out_rem     <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (in_range && fits) begin
            case (scan_mode)
              fpba_pkg::FIT_FIRST: begin
                if (!found) begin
                  found    <= 1'b1;
                  pick     <= k[IW-1:0];
                  pick_rem <= head_rem;
                end
              end
              fpba_pkg::FIT_NEXT: begin
                if (!found) begin
                  found    <= 1'b1;
                  pick     <= k[IW-1:0];
                  pick_rem <= head_rem;
                end
                // First fit at or after the start pointer wins over a wrapped one.
                if (!found_hi && (k >= KW'(scan_start))) begin
                  found_hi <= 1'b1;
                  pick_hi  <= k[IW-1:0];
                  rem_hi   <= head_rem;
                end
              end
              fpba_pkg::FIT_BEST: begin
                if (!found || (head_rem < pick_rem)) begin
                  found    <= 1'b1;
                  pick     <= k[IW-1:0];
                  pick_rem <= head_rem;
                end
              end
              default: begin
                if (!found || (head_rem > pick_rem)) begin
                  found    <= 1'b1;
                  pick     <= k[IW-1:0];
                  pick_rem <= head_rem;
                end
              end
            endcase
          end
          k <= k + 1'b1;
          if (k == KW'(MAX_BLOCKS - 1)) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          out_valid   <= 1'b1;
          out_granted <= found;
          out_block   <= found ? pick_x[5:0] : 6'd0;
          out_rem     <= found ? left_x[15:0] : 16'd0;
          if (found && (scan_mode == fpba_pkg::FIT_NEXT)) begin
            next_ptr <= use_pick;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.granted         = out_granted;
  assign res.chosen_block    = out_block;
  assign res.remaining_after = out_rem;

endmodule

>>> rtl/core/fpba_check.sv
// Port-level checker for the partition allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator_assert.svh.
`include "fit_policy_block_allocator_assert.svh"

module fpba_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_type,
  input logic        res_valid,
  input logic        res_ready,
  input logic        granted,
  input logic [5:0]  chosen_block,
  input logic [15:0] remaining_after
);

  // A stalled result item holds its value.
  `FPBA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(granted) && $stable(chosen_block) && $stable(remaining_after))

  // A result without a grant, such as a refused allocation, reports no block and no size.
  `FPBA_ASSERT_IMPL(a_deny_zero, res_valid && !granted,
    (chosen_block == 6'd0) && (remaining_after == 16'd0))

  // Any request other than an allocation answers in the next cycle.
  `FPBA_ASSERT_NEXT(a_fast_reply,
    req_valid && req_ready && (req_type != fpba_pkg::REQ_ALLOC), res_valid)

  // An allocation occupies the scanner, so no request is taken right after it.
  `FPBA_ASSERT_NEXT(a_alloc_busy,
    req_valid && req_ready && (req_type == fpba_pkg::REQ_ALLOC), !req_ready)

endmodule

bind fit_policy_block_allocator fpba_check u_fpba_check (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_type        (req.req_type),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .granted         (res.granted),
  .chosen_block    (res.chosen_block),
  .remaining_after (res.remaining_after)
);

>>> sim/fit_policy_block_allocator_tb.sv
// Self-checking testbench for the partition allocator: directed requests, then random
// load, allocate and restore traffic under every placement policy and several block counts.
// Depends on fpba_pkg, fpba_if and fit_policy_block_allocator.
module fit_policy_block_allocator_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_SETTING = 50;
  localparam int SETTING_COUNT = 12;
  localparam int TABLE_DEPTH = 64;
  // Request code that the block accepts but ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic        granted;
    logic [5:0]  chosen_block;
    logic [15:0] remaining_after;
  } grant_t;

  // Mirrors the partition table and predicts the result of every accepted request.
  class grant_tracker;
    fpba_pkg::fit_mode_t mode;
    logic [6:0]  count;
    logic [15:0] orig_size [TABLE_DEPTH];
    logic [15:0] rem_size [TABLE_DEPTH];
    bit          loaded [TABLE_DEPTH];
    logic [5:0]  next_ptr;
    grant_t      pending_grants [$];
    int          fault_count;

    function new();
      mode = fpba_pkg::FIT_FIRST;
      count = fpba_pkg::BLOCK_COUNT_RESET;
      next_ptr = '0;
      fault_count = 0;
      foreach (loaded[i]) begin
        loaded[i] = 0;
        orig_size[i] = '0;
        rem_size[i] = '0;
      end
    endfunction

    function int used_count();
      return (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    endfunction

    function int first_unloaded();
      for (int j = 0; j < used_count(); j++)
        if (!loaded[j]) return j;
      return -1;
    endfunction

    function int find_block(logic [15:0] need);
      int n;
      int p;
      int pick;
      n = used_count();
      pick = -1;
      if (mode == fpba_pkg::FIT_NEXT) begin
        p = (next_ptr < n) ? int'(next_ptr) : 0;
        for (int j = 0; j < n; j++) begin
          if (rem_size[p] >= need) begin
            next_ptr = 6'(p);
            return p;
          end
          p = (p + 1 == n) ? 0 : p + 1;
        end
        return -1;
      end
      for (int j = 0; j < n; j++) begin
        if (rem_size[j] < need) continue;
        if (mode == fpba_pkg::FIT_FIRST) return j;
        if (pick < 0 ||
            (mode == fpba_pkg::FIT_BEST && rem_size[j] < rem_size[pick]) ||
            (mode == fpba_pkg::FIT_WORST && rem_size[j] > rem_size[pick]))
          pick = j;
      end
      return pick;
    endfunction

    function void note_request(logic [1:0] kind, logic [5:0] idx, logic [15:0] size);
      grant_t g;
      int pick;
      g = '0;
      case (kind)
        fpba_pkg::REQ_LOAD: begin
          orig_size[idx] = size;
          rem_size[idx] = size;
          loaded[idx] = 1;
        end
        fpba_pkg::REQ_ALLOC: begin
          pick = find_block(size);
          if (pick >= 0) begin
            rem_size[pick] = rem_size[pick] - size;
            g.granted = 1'b1;
            g.chosen_block = 6'(pick);
            g.remaining_after = rem_size[pick];
          end
        end
        fpba_pkg::REQ_RESTORE: begin
          rem_size = orig_size;
          next_ptr = '0;
        end
        default: ;
      endcase
      pending_grants.push_back(g);
    endfunction

    function void check_result(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $error("result item with no request outstanding: granted %0d block %0d remaining %0d",
               got.granted, got.chosen_block, got.remaining_after);
        fault_count++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, actual %0d", want.granted, got.granted);
        fault_count++;
      end
      if (got.chosen_block !== want.chosen_block) begin
        $error("chosen_block: expected %0d, actual %0d", want.chosen_block, got.chosen_block);
        fault_count++;
      end
      if (got.remaining_after !== want.remaining_after) begin
        $error("remaining_after: expected %0d, actual %0d",
               want.remaining_after, got.remaining_after);
        fault_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [fpba_pkg::CFG_DATA_BITS-1:0] cfg_data;

  fpba_req_if req_ch();
  fpba_res_if res_ch();

  grant_tracker sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count = 0;

  fpba_pkg::fit_mode_t seg_mode [SETTING_COUNT] = '{
    fpba_pkg::FIT_FIRST, fpba_pkg::FIT_NEXT, fpba_pkg::FIT_BEST, fpba_pkg::FIT_WORST,
    fpba_pkg::FIT_NEXT, fpba_pkg::FIT_BEST, fpba_pkg::FIT_FIRST, fpba_pkg::FIT_WORST,
    fpba_pkg::FIT_BEST, fpba_pkg::FIT_NEXT, fpba_pkg::FIT_WORST, fpba_pkg::FIT_FIRST};
  int seg_count [SETTING_COUNT] = '{8, 5, 1, 64, 127, 16, 0, 2, 64, 0, 0, 32};

  fit_policy_block_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fit_policy_block_allocator_tb: errors");
      $finish;
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.granted, res_ch.chosen_block, res_ch.remaining_after});
  end

  task automatic send_item(logic [1:0] kind, logic [5:0] idx, logic [15:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.block_index <= idx;
    req_ch.size_value <= size;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, idx, size);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending_grants.size() != 0) @(negedge clk);
  endtask

  // Registers are written only with the block idle.
  task automatic apply_setting(fpba_pkg::fit_mode_t mode, int count);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= fpba_pkg::CFG_FIT_MODE;
    cfg_data <= fpba_pkg::CFG_DATA_BITS'(mode);
    @(negedge clk);
    cfg_index <= fpba_pkg::CFG_BLOCK_COUNT;
    cfg_data <= fpba_pkg::CFG_DATA_BITS'(count);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.mode = mode;
    sb.count = 7'(count);
    @(negedge clk);
  endtask

  // Small and repeated sizes make ties and exhausted blocks common.
  function automatic logic [15:0] rand_load_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 16'($urandom_range(31));
    if (roll < 70) begin
      case ($urandom_range(3))
        0: return 16'd16;
        1: return 16'd64;
        2: return 16'd100;
        default: return 16'd1000;
      endcase
    end
    if (roll < 90) return 16'($urandom_range(16'hFFFF));
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic logic [15:0] rand_request_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return 16'($urandom_range(15));
    if (roll < 60) return 16'($urandom_range(127, 16));
    if (roll < 80) return 16'($urandom_range(16'hFFFF));
    if (roll < 90) return 16'h0000;
    return 16'hFFFF;
  endfunction

  // Returns 0 when the item was one the block ignores.
  task automatic send_random_request(output bit counted);
    int roll;
    int gap;
    int n;
    roll = $urandom_range(99);
    n = sb.used_count();
    counted = 1;
    if (roll < 50) begin
      // Entries in use must all be loaded before an allocate may scan them.
      gap = sb.first_unloaded();
      if (gap >= 0)
        send_item(fpba_pkg::REQ_LOAD, 6'(gap), rand_load_size());
      else
        send_item(fpba_pkg::REQ_ALLOC, 6'($urandom_range(63)), rand_request_size());
    end else if (roll < 85) begin
      if (n > 0 && $urandom_range(4) != 0)
        send_item(fpba_pkg::REQ_LOAD, 6'($urandom_range(n - 1)), rand_load_size());
      else
        send_item(fpba_pkg::REQ_LOAD, 6'($urandom_range(63)), rand_load_size());
    end else if (roll < 93) begin
      send_item(fpba_pkg::REQ_RESTORE, 6'($urandom_range(63)),
                16'($urandom_range(16'hFFFF)));
    end else begin
      send_item(REQ_UNUSED, 6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)));
      counted = 0;
    end
  endtask

  initial begin
    int sent;
    bit counted;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fpba_pkg::CFG_FIT_MODE;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = fpba_pkg::REQ_LOAD;
    req_ch.block_index = '0;
    req_ch.size_value = '0;
    send_idle_pct = 20;
    recv_idle_pct = 82;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apply_setting(fpba_pkg::FIT_FIRST, 4);
    send_item(fpba_pkg::REQ_LOAD, 0, 16'hFFFF);
    send_item(fpba_pkg::REQ_LOAD, 1, 16'h0000);
    send_item(fpba_pkg::REQ_LOAD, 2, 16'd100);
    send_item(fpba_pkg::REQ_LOAD, 3, 16'd100);
    send_item(fpba_pkg::REQ_LOAD, 63, 16'hAAAA);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'h0000);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'hFFFF);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'hFFFF);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd100);
    send_item(REQ_UNUSED, 63, 16'hFFFF);
    send_item(fpba_pkg::REQ_RESTORE, 0, 16'h0000);
    // Blocks 2 and 3 tie for best fit.
    apply_setting(fpba_pkg::FIT_BEST, 4);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd50);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd60);
    apply_setting(fpba_pkg::FIT_WORST, 4);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd1);
    send_item(fpba_pkg::REQ_RESTORE, 0, 16'h0000);
    // Walk the next-fit pointer to block 3, fail a scan, then shrink the count below it.
    apply_setting(fpba_pkg::FIT_NEXT, 4);
    send_item(fpba_pkg::REQ_LOAD, 0, 16'd5);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd100);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd100);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'd200);
    apply_setting(fpba_pkg::FIT_NEXT, 2);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'h0000);
    apply_setting(fpba_pkg::FIT_FIRST, 0);
    send_item(fpba_pkg::REQ_ALLOC, 0, 16'h0000);

    seg_count[9] = $urandom_range(63, 3);
    seg_count[10] = $urandom_range(126, 65);
    for (int seg = 0; seg < SETTING_COUNT; seg++) begin
      apply_setting(seg_mode[seg], seg_count[seg]);
      case (seg / 4)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        send_random_request(counted);
        if (counted) sent++;
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.fault_count == 0)
      $display("fit_policy_block_allocator_tb: clean");
    else
      $display("fit_policy_block_allocator_tb: errors");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/fpba_pkg.sv
rtl/core/fpba_if.sv
rtl/core/fpba_cell.sv
rtl/core/fit_policy_block_allocator.sv
rtl/core/fpba_check.sv
sim/fit_policy_block_allocator_tb.sv
